// File: hdl/sldf_pkg.sv
package sldf_pkg;

    localparam int unsigned WORD_W = 16;
    localparam int unsigned CNT_W  = 13;
    localparam int unsigned EV_W   = 4;
    localparam int unsigned FUNC_W = 2;

    localparam logic [WORD_W-1:0] W_IDLE   = 16'hFFFF;
    localparam logic [WORD_W-1:0] W_START  = 16'hFFFA;
    localparam logic [WORD_W-1:0] W_END    = 16'hFFF5;
    localparam logic [WORD_W-1:0] W_ESC    = 16'h7FFF;
    localparam logic [WORD_W-1:0] W_XOR    = 16'h4000;
    localparam logic [WORD_W-1:0] CMD_NONE = 16'hFFFF;
    localparam logic [WORD_W-1:0] CMD_LO   = 16'h8000;
    localparam logic [WORD_W-1:0] CMD_HI   = 16'h8005;

    localparam logic [CNT_W-1:0] CNT_MAX       = '1;
    localparam logic [CNT_W-1:0] MAX_WORDS_RST = 13'd1024;

    localparam logic [FUNC_W-1:0] FUNC_LINK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ISSUE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [EV_W-1:0] EV_ABSORB  = 4'd0;
    localparam logic [EV_W-1:0] EV_START   = 4'd1;
    localparam logic [EV_W-1:0] EV_DATA    = 4'd2;
    localparam logic [EV_W-1:0] EV_END     = 4'd3;
    localparam logic [EV_W-1:0] EV_DROP    = 4'd4;
    localparam logic [EV_W-1:0] EV_ACK     = 4'd5;
    localparam logic [EV_W-1:0] EV_ACCEPT  = 4'd6;
    localparam logic [EV_W-1:0] EV_BUSY    = 4'd7;
    localparam logic [EV_W-1:0] EV_INVALID = 4'd8;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic        REG_MAX_WORDS = 1'b0;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [WORD_W-1:0] rx_word;
        logic [WORD_W-1:0] cmd_code;
    } item_t;

    typedef struct packed {
        logic [EV_W-1:0]   event_res;
        logic [WORD_W-1:0] data_word;
        logic [CNT_W-1:0]  packet_length;
        logic              command_pending;
    } result_t;

endpackage

// File: hdl/sldf_regs.sv
module sldf_regs
    import sldf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [CNT_W-1:0]   max_words
);

    logic [CNT_W-1:0] max_words_reg;
    logic             wr_max;

    assign pready = 1'b1;
    assign wr_max = psel && penable && pwrite && (paddr[2] == REG_MAX_WORDS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_words_reg <= MAX_WORDS_RST;
        end
        else if (wr_max)
        begin
            max_words_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MAX_WORDS)
        begin
            prdata = {{(PDATA_W-CNT_W){1'b0}}, max_words_reg};
        end
    end

    assign max_words = max_words_reg;

endmodule

// File: hdl/sldf_engine.sv
module sldf_engine
    import sldf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  item_t            item,
    input  logic [CNT_W-1:0] max_words,
    output result_t          result
);

    typedef enum logic [1:0] {
        MODE_ACK_WORD,
        MODE_ACK_DATA,
        MODE_PACKET,
        MODE_ESCAPED
    } mode_t;

    mode_t             mode_reg,      mode_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic [WORD_W-1:0] ack_word_reg,  ack_word_next;
    logic [WORD_W-1:0] pending_reg,   pending_next;

    logic              keep_ok;
    logic [WORD_W-1:0] kept_word;

    assign keep_ok   = (count_reg <= max_words) && (count_reg != CNT_MAX);
    assign kept_word = (mode_reg == MODE_ESCAPED) ? (item.rx_word ^ W_XOR) : item.rx_word;

    always_comb
    begin
        mode_next              = mode_reg;
        count_next             = count_reg;
        ack_word_next          = ack_word_reg;
        pending_next           = pending_reg;
        result.event_res       = EV_ABSORB;
        result.data_word       = '0;
        result.packet_length   = '0;

        case (item.func)
            FUNC_LINK:
            begin
                if (item.rx_word == W_IDLE)
                begin
                    result.event_res = EV_ABSORB;
                end
                else if (item.rx_word == W_START)
                begin
                    mode_next        = MODE_PACKET;
                    count_next       = '0;
                    result.event_res = EV_START;
                end
                else
                begin
                    unique case (mode_reg)
                        MODE_ACK_WORD:
                        begin
                            ack_word_next = item.rx_word;
                            mode_next     = MODE_ACK_DATA;
                        end
                        MODE_ACK_DATA:
                        begin
                            mode_next = MODE_ACK_WORD;
                            if (ack_word_reg == (pending_reg | W_XOR))
                            begin
                                pending_next     = CMD_NONE;
                                result.event_res = EV_ACK;
                            end
                        end
                        MODE_PACKET, MODE_ESCAPED:
                        begin
                            if (mode_reg == MODE_PACKET && item.rx_word == W_END)
                            begin
                                mode_next            = MODE_ACK_WORD;
                                result.packet_length = count_reg;
                                result.event_res     = EV_END;
                            end
                            else if (mode_reg == MODE_PACKET && item.rx_word == W_ESC)
                            begin
                                mode_next = MODE_ESCAPED;
                            end
                            else
                            begin
                                mode_next = MODE_PACKET;
                                if (keep_ok)
                                begin
                                    result.data_word = kept_word;
                                    count_next       = count_reg + 1'b1;
                                    result.event_res = EV_DATA;
                                end
                                else
                                begin
                                    result.event_res = EV_DROP;
                                end
                            end
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
            end
            FUNC_ISSUE:
            begin
                if (pending_reg != CMD_NONE)
                begin
                    result.event_res = EV_BUSY;
                end
                else if (item.cmd_code == CMD_NONE)
                begin
                    result.event_res = EV_ACCEPT;
                end
                else if (item.cmd_code >= CMD_LO && item.cmd_code <= CMD_HI)
                begin
                    pending_next     = item.cmd_code;
                    result.event_res = EV_ACCEPT;
                end
                else
                begin
                    result.event_res = EV_INVALID;
                end
            end
            FUNC_CLEAR:
            begin
                pending_next = CMD_NONE;
            end
            default:
            begin
                result.event_res = EV_ABSORB;
            end
        endcase

        result.command_pending = (pending_next != CMD_NONE);
    end

    // state moves only when the transaction passes into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_ACK_WORD;
            count_reg    <= '0;
            ack_word_reg <= '0;
            pending_reg  <= CMD_NONE;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            count_reg    <= count_next;
            ack_word_reg <= ack_word_next;
            pending_reg  <= pending_next;
        end
    end

endmodule

// File: hdl/spi_link_rx_deframer_core.sv
// Path: an accepted transaction passes through the input register, then the result
// register (a stalled output holds it in the input register); the result stays until taken.
// Throughput: one transaction per cycle while the output is not stalled; the mode updates combinationally.
// Reset: rst_n clears both valid flags, the receive mode, count, ack word and
// pending command, and loads the packet limit with 1024.
module spi_link_rx_deframer_core
    import sldf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FUNC_W-1:0]  func,
    input  logic [WORD_W-1:0]  rx_word,
    input  logic [WORD_W-1:0]  cmd_code,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [EV_W-1:0]    event_res,
    output logic [WORD_W-1:0]  data_word,
    output logic [CNT_W-1:0]   packet_length,
    output logic               command_pending
);

    logic             in_valid_reg;
    item_t            item_reg;
    logic             out_valid_reg;
    result_t          result_reg;
    result_t          result_next;
    logic             advance;
    logic [CNT_W-1:0] max_words;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    sldf_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .max_words (max_words)
    );

    sldf_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (item_reg),
        .max_words (max_words),
        .result    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.func     <= func;
            item_reg.rx_word  <= rx_word;
            item_reg.cmd_code <= cmd_code;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign event_res       = result_reg.event_res;
    assign data_word       = result_reg.data_word;
    assign packet_length   = result_reg.packet_length;
    assign command_pending = result_reg.command_pending;

endmodule

// File: hdl/sldf_checker.sv
module sldf_checker
    import sldf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [EV_W-1:0]   event_res,
    input logic [WORD_W-1:0] data_word,
    input logic [CNT_W-1:0]  packet_length,
    input logic              command_pending
);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res)
            && $stable(data_word) && $stable(packet_length))
        else $error("result changed while stalled");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != EV_DATA |-> data_word == '0)
        else $error("data word set outside a data event");

    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != EV_END |-> packet_length == '0)
        else $error("packet length set outside an end event");

    a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_ACK || event_res == EV_INVALID) |-> !command_pending)
        else $error("command still pending after ack or invalid issue");

    a_busy_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_BUSY |-> command_pending)
        else $error("busy reported with no pending command");

endmodule

bind spi_link_rx_deframer_core sldf_checker u_sldf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .event_res       (event_res),
    .data_word       (data_word),
    .packet_length   (packet_length),
    .command_pending (command_pending)
);

// File: verif/tb_spi_link_rx_deframer_core.sv
module tb_spi_link_rx_deframer_core
    import sldf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int unsigned HOLD_CYCLES = 400;

    typedef enum logic [1:0] {
        RX_ACK_HEAD = 2'd0,
        RX_ACK_TAIL = 2'd1,
        RX_PACKET   = 2'd2,
        RX_ESCAPED  = 2'd3
    } rx_state_t;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
    } link_txn_t;

    typedef struct {
        bit                cfg;
        logic [FUNC_W-1:0] func;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] code;
        bit                typed;
        result_t           want;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [FUNC_W-1:0]  func = FUNC_LINK;
    logic [WORD_W-1:0]  rx_word = '0;
    logic [WORD_W-1:0]  cmd_code = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [EV_W-1:0]    event_res;
    logic [WORD_W-1:0]  data_word;
    logic [CNT_W-1:0]   packet_length;
    logic               command_pending;

    // deframer state mirror
    logic [CNT_W-1:0]  limit_words = MAX_WORDS_RST;
    rx_state_t         rx_state = RX_ACK_HEAD;
    logic [CNT_W-1:0]  kept_count = '0;
    logic [WORD_W-1:0] ack_head = '0;
    logic [WORD_W-1:0] cmd_open = CMD_NONE;

    link_txn_t   link_items[$];
    result_t     deframer_events[$];
    dir_row_t    dir_table[$];
    link_txn_t   cur_tx;
    int unsigned gen_count = 0;
    int unsigned mismatches = 0;
    int unsigned hold_reqs = 0;
    bit          in_fire = 1'b0;
    bit          out_fire = 1'b0;

    spi_link_rx_deframer_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .rx_word         (rx_word),
        .cmd_code        (cmd_code),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .event_res       (event_res),
        .data_word       (data_word),
        .packet_length   (packet_length),
        .command_pending (command_pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void keep_word(input logic [WORD_W-1:0] w, inout result_t r);
        if (kept_count <= limit_words && kept_count < CNT_MAX)
        begin
            r.event_res = EV_DATA;
            r.data_word = w;
            kept_count = kept_count + 1'b1;
        end
        else
            r.event_res = EV_DROP;
    endfunction

    function automatic result_t deframer_next(item_t it);
        result_t r;
        r = '0;
        r.event_res = EV_ABSORB;
        case (it.func)
            FUNC_LINK:
            begin
                if (it.rx_word == W_START)
                begin
                    rx_state = RX_PACKET;
                    kept_count = '0;
                    r.event_res = EV_START;
                end
                else if (it.rx_word != W_IDLE)
                begin
                    case (rx_state)
                        RX_ACK_HEAD:
                        begin
                            ack_head = it.rx_word;
                            rx_state = RX_ACK_TAIL;
                        end
                        RX_ACK_TAIL:
                        begin
                            rx_state = RX_ACK_HEAD;
                            if (ack_head == (cmd_open | W_XOR))
                            begin
                                cmd_open = CMD_NONE;
                                r.event_res = EV_ACK;
                            end
                        end
                        RX_PACKET:
                        begin
                            if (it.rx_word == W_END)
                            begin
                                rx_state = RX_ACK_HEAD;
                                r.event_res = EV_END;
                                r.packet_length = kept_count;
                            end
                            else if (it.rx_word == W_ESC)
                                rx_state = RX_ESCAPED;
                            else
                                keep_word(it.rx_word, r);
                        end
                        default:
                        begin
                            rx_state = RX_PACKET;
                            keep_word(it.rx_word ^ W_XOR, r);
                        end
                    endcase
                end
            end
            FUNC_ISSUE:
            begin
                if (cmd_open != CMD_NONE)
                    r.event_res = EV_BUSY;
                else if (it.cmd_code == CMD_NONE)
                    r.event_res = EV_ACCEPT;
                else if (it.cmd_code >= CMD_LO && it.cmd_code <= CMD_HI)
                begin
                    cmd_open = it.cmd_code;
                    r.event_res = EV_ACCEPT;
                end
                else
                    r.event_res = EV_INVALID;
            end
            FUNC_CLEAR:
                cmd_open = CMD_NONE;
            default:
            begin
            end
        endcase
        r.command_pending = (cmd_open != CMD_NONE);
        return r;
    endfunction

    function automatic void push_item(logic [FUNC_W-1:0] f, logic [WORD_W-1:0] w,
                                      logic [WORD_W-1:0] c);
        link_txn_t t;
        t.it.func = f;
        t.it.rx_word = w;
        t.it.cmd_code = c;
        t.typed = 1'b0;
        t.want = '0;
        link_items.push_back(t);
        gen_count++;
    endfunction

    function automatic void push_link(logic [WORD_W-1:0] w);
        push_item(FUNC_LINK, w, WORD_W'($urandom));
    endfunction

    function automatic logic [WORD_W-1:0] special_word();
        case ($urandom_range(0, 7))
            0: return W_END;
            1: return W_ESC;
            2: return W_START;
            3: return W_IDLE;
            4: return W_XOR;
            5: return 16'h0000;
            6: return 16'hBFFF;
            default: return 16'hFFFE;
        endcase
    endfunction

    // move a word off idle and start so it stays inside the current pair
    function automatic logic [WORD_W-1:0] link_safe(logic [WORD_W-1:0] w);
        if (w == W_IDLE || w == W_START)
            return w ^ 16'h0100;
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] packet_word();
        logic [WORD_W-1:0] w;
        w = WORD_W'($urandom);
        if ($urandom_range(0, 11) == 0)
            w = special_word();
        else if (w == W_IDLE || w == W_START || w == W_END || w == W_ESC)
            w = ~w;
        return w;
    endfunction

    function automatic void gen_packet(int unsigned limit);
        int unsigned len;
        int unsigned fin;
        if (limit <= 40)
            len = $urandom_range(0, limit + 3);
        else if ($urandom_range(0, 6) == 0)
            len = $urandom_range(41, 200);
        else
            len = $urandom_range(0, 40);
        push_link(W_START);
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                push_link(W_IDLE);
            if ($urandom_range(0, 5) == 0)
            begin
                push_link(W_ESC);
                if ($urandom_range(0, 2) == 0)
                    push_link(special_word());
                else
                    push_link(WORD_W'($urandom));
            end
            else
                push_link(packet_word());
        end
        fin = $urandom_range(0, 19);
        if (fin < 17)
            push_link(W_END);
        else if (fin == 19)
            push_link(W_ESC);
    endfunction

    function automatic void gen_ack_pair();
        logic [WORD_W-1:0] head;
        case ($urandom_range(0, 3))
            0, 1: head = W_XOR | (CMD_LO + WORD_W'($urandom_range(0, 5)));
            2: head = link_safe(W_XOR | WORD_W'($urandom));
            default: head = link_safe(WORD_W'($urandom));
        endcase
        push_link(head);
        if ($urandom_range(0, 7) == 0)
            push_link(W_IDLE);
        push_link(link_safe(WORD_W'($urandom)));
    endfunction

    function automatic void gen_command();
        int unsigned k;
        logic [WORD_W-1:0] code;
        k = $urandom_range(0, 19);
        if (k < 4)
            push_item(FUNC_CLEAR, WORD_W'($urandom), WORD_W'($urandom));
        else if (k == 4)
            push_item(FUNC_UNUSED, WORD_W'($urandom), WORD_W'($urandom));
        else
        begin
            k = $urandom_range(0, 19);
            if (k < 12)
                code = CMD_LO + WORD_W'($urandom_range(0, 5));
            else if (k < 15)
                code = CMD_NONE;
            else
                code = WORD_W'($urandom);
            push_item(FUNC_ISSUE, WORD_W'($urandom), code);
        end
    endfunction

    function automatic void gen_traffic(int unsigned limit, int unsigned n);
        int unsigned target;
        int unsigned kind;
        target = gen_count + n;
        while (gen_count < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 50)
                gen_packet(limit);
            else if (kind < 75)
                gen_ack_pair();
            else if (kind < 95)
                gen_command();
            else
                push_link(WORD_W'($urandom));
        end
    endfunction

    function automatic void row_p(logic [FUNC_W-1:0] f, logic [WORD_W-1:0] w,
                                  logic [WORD_W-1:0] c);
        dir_row_t d;
        d.cfg = 1'b0;
        d.func = f;
        d.word = w;
        d.code = c;
        d.typed = 1'b0;
        d.want = '0;
        dir_table.push_back(d);
    endfunction

    function automatic void row_t(logic [FUNC_W-1:0] f, logic [WORD_W-1:0] w,
                                  logic [WORD_W-1:0] c, logic [EV_W-1:0] ev,
                                  logic [WORD_W-1:0] data, logic [CNT_W-1:0] len,
                                  logic pend);
        dir_row_t d;
        d.cfg = 1'b0;
        d.func = f;
        d.word = w;
        d.code = c;
        d.typed = 1'b1;
        d.want = {ev, data, len, pend};
        dir_table.push_back(d);
    endfunction

    function automatic void row_cfg(logic [CNT_W-1:0] limit);
        dir_row_t d;
        d = '{cfg: 1'b1, func: FUNC_LINK, word: '0, code: WORD_W'(limit),
              typed: 1'b0, want: '0};
        dir_table.push_back(d);
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (link_items.size() != 0 || in_valid || deframer_events.size() != 0);
    endtask

    task automatic write_limit(logic [CNT_W-1:0] limit);
        logic [PDATA_W-1:0] wdata;
        wdata = $urandom;
        wdata[CNT_W-1:0] = limit;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * int'(REG_MAX_WORDS));
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        limit_words = limit;
    endtask

    // sender: bursts of random length separated by random gaps
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!in_valid || in_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (link_items.size() > 0)
            begin
                cur_tx = link_items.pop_front();
                in_valid <= 1'b1;
                func <= cur_tx.it.func;
                rx_word <= cur_tx.it.rx_word;
                cmd_code <= cur_tx.it.cmd_code;
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 24);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: stall pattern reloaded now and then, plus requested long holds
    logic [15:0] stall_pat;
    int unsigned pat_left;
    int unsigned hold_left;
    int unsigned hold_seen;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_pat = '1;
            pat_left = 0;
            hold_left = 0;
            hold_seen = 0;
        end
        else
        begin
            if (hold_seen != hold_reqs)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (pat_left == 0)
            begin
                pat_left = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0: stall_pat = '1;
                    1: stall_pat = 16'($urandom);
                    2: stall_pat = 16'($urandom & $urandom);
                    default: stall_pat = 16'($urandom | $urandom);
                endcase
            end
            pat_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= stall_pat[pat_left[3:0]];
        end
    end

    // sample both handshakes mid-cycle, away from the driving edge
    always @(negedge clk)
    begin
        result_t want;
        result_t got;
        in_fire = rst_n && in_valid && in_ready;
        out_fire = rst_n && out_valid && out_ready;
        if (in_fire)
        begin
            want = deframer_next(cur_tx.it);
            if (cur_tx.typed)
                want = cur_tx.want;
            deframer_events.push_back(want);
        end
        if (out_fire)
        begin
            got = {event_res, data_word, packet_length, command_pending};
            if (deframer_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR @%0t: unexpected result ev=%0d data=%h len=%0d pend=%0b",
                             $time, got.event_res, got.data_word, got.packet_length,
                             got.command_pending);
            end
            else
            begin
                want = deframer_events.pop_front();
                if (got.event_res !== want.event_res || got.data_word !== want.data_word
                    || got.packet_length !== want.packet_length
                    || got.command_pending !== want.command_pending)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR @%0t: exp %0d/%h/%0d/%0b got %0d/%h/%0d/%0b",
                                 $time, want.event_res, want.data_word, want.packet_length,
                                 want.command_pending, got.event_res, got.data_word,
                                 got.packet_length, got.command_pending);
                end
            end
        end
    end

    initial
    begin
        link_txn_t t;
        logic [CNT_W-1:0] phase_limit [8];

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // after reset: idle word, then command issue rules
        row_t(FUNC_LINK,   W_IDLE,   16'h0000, EV_ABSORB,  16'h0, 13'd0, 1'b0);
        row_t(FUNC_ISSUE,  16'h0000, 16'h8006, EV_INVALID, 16'h0, 13'd0, 1'b0);
        row_t(FUNC_ISSUE,  16'h0000, CMD_NONE, EV_ACCEPT,  16'h0, 13'd0, 1'b0);
        row_t(FUNC_ISSUE,  16'h0000, CMD_LO,   EV_ACCEPT,  16'h0, 13'd0, 1'b1);
        row_t(FUNC_ISSUE,  16'h0000, CMD_HI,   EV_BUSY,    16'h0, 13'd0, 1'b1);
        // ack pair that matches the pending command
        row_t(FUNC_LINK,   16'hC000, 16'h0000, EV_ABSORB,  16'h0, 13'd0, 1'b1);
        row_t(FUNC_LINK,   16'h1234, 16'h0000, EV_ACK,     16'h0, 13'd0, 1'b0);
        row_t(FUNC_ISSUE,  16'h0000, CMD_HI,   EV_ACCEPT,  16'h0, 13'd0, 1'b1);
        row_t(FUNC_CLEAR,  16'h0000, 16'h0000, EV_ABSORB,  16'h0, 13'd0, 1'b0);
        row_t(FUNC_UNUSED, W_IDLE,   CMD_NONE, EV_ABSORB,  16'h0, 13'd0, 1'b0);
        // packet with start inside escape, escaped end, escape and idle
        row_t(FUNC_LINK,   W_START,  16'h0000, EV_START,   16'h0, 13'd0, 1'b0);
        row_t(FUNC_LINK,   16'h0000, 16'h0000, EV_DATA,    16'h0, 13'd0, 1'b0);
        row_t(FUNC_LINK,   W_ESC,    16'h0000, EV_ABSORB,  16'h0, 13'd0, 1'b0);
        row_t(FUNC_LINK,   W_START,  16'h0000, EV_START,   16'h0, 13'd0, 1'b0);
        row_p(FUNC_LINK,   W_ESC,    16'h0000);
        row_t(FUNC_LINK,   W_END,    16'h0000, EV_DATA,    16'hBFF5, 13'd0, 1'b0);
        row_p(FUNC_LINK,   W_ESC,    16'hFFFF);
        row_t(FUNC_LINK,   W_ESC,    16'h0000, EV_DATA,    16'h3FFF, 13'd0, 1'b0);
        row_p(FUNC_LINK,   W_ESC,    16'h0000);
        row_t(FUNC_LINK,   W_IDLE,   16'h0000, EV_ABSORB,  16'h0, 13'd0, 1'b0);
        row_t(FUNC_LINK,   W_XOR,    16'h0000, EV_DATA,    16'h0, 13'd0, 1'b0);
        row_t(FUNC_LINK,   W_END,    16'h0000, EV_END,     16'h0, 13'd3, 1'b0);
        // zero limit still keeps one word
        row_cfg(13'd0);
        row_t(FUNC_LINK,   W_START,  16'h0000, EV_START,   16'h0, 13'd0, 1'b0);
        row_p(FUNC_LINK,   16'h0001, 16'hFFFF);
        row_t(FUNC_LINK,   16'h0002, 16'h0000, EV_DROP,    16'h0, 13'd0, 1'b0);
        row_t(FUNC_LINK,   W_END,    16'h0000, EV_END,     16'h0, 13'd1, 1'b0);

        foreach (dir_table[i])
        begin
            if (dir_table[i].cfg)
            begin
                wait_idle();
                write_limit(dir_table[i].code[CNT_W-1:0]);
            end
            else
            begin
                t.it.func = dir_table[i].func;
                t.it.rx_word = dir_table[i].word;
                t.it.cmd_code = dir_table[i].code;
                t.typed = dir_table[i].typed;
                t.want = dir_table[i].want;
                link_items.push_back(t);
            end
        end

        phase_limit = '{13'd1, 13'd4096, 13'd0, CNT_MAX, 13'd5, MAX_WORDS_RST, 13'd23, 13'd1};
        phase_limit[4] = CNT_W'($urandom_range(2, 30));

        for (int p = 0; p < 8; p++)
        begin
            wait_idle();
            write_limit(phase_limit[p]);
            gen_traffic(phase_limit[p], 100);
            // hold the sender until every queued result is back
            wait_idle();
            if (p == 2 || p == 6)
                hold_reqs++;
            gen_traffic(phase_limit[p], 100);
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && deframer_events.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
